// ----- hw/rtl/frm_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the frame FCS appender.
// No dependencies; every other RTL file of the block imports this package.
package frm_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  FLAG_INIT = 8'h7E;

    typedef enum logic [1:0] {
        KIND_FLAG = 2'd0,
        KIND_BODY = 2'd1,
        KIND_FCS  = 2'd2
    } kind_t;

    // Position of the next beat within the group that one body byte causes.
    typedef enum logic [2:0] {
        STEP_OPEN   = 3'd0,
        STEP_BODY   = 3'd1,
        STEP_FCS_LO = 3'd2,
        STEP_FCS_HI = 3'd3,
        STEP_CLOSE  = 3'd4
    } step_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      byte_kind;
        logic       run_last;
    } out_beat_t;

    // One accepted body byte with everything needed to send its beats.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        open_frame;
        logic [15:0] fcs;
    } frm_rec_t;

    // MSB-first CRC-16 update with polynomial 0x1021, one byte at a time.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/frm_front.sv -----
// Input stage of the frame FCS appender: running CRC, frame state and the item record.
// Depends on frm_pkg; the record is released by frm_emit when its last beat is sent.
module frm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  frm_pkg::in_beat_t in_beat,
    input  logic              release_rec,
    output logic              rec_valid,
    output frm_pkg::frm_rec_t rec
);
    import frm_pkg::*;

    logic        accept;
    logic [15:0] crc_fold_val;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        inside_reg;
    logic        inside_next;
    logic        rec_valid_reg;
    logic        rec_valid_next;
    frm_rec_t    rec_reg;
    frm_rec_t    rec_next;

    // A new byte may enter in the same cycle that the current record sends its final beat.
    assign in_stall = rec_valid_reg && !release_rec;
    assign accept   = in_valid && !in_stall;

    assign crc_fold_val = crc_fold(crc_reg, in_beat.data_byte);

    always_comb
    begin
        crc_next       = crc_reg;
        inside_next    = inside_reg;
        rec_valid_next = rec_valid_reg && !release_rec;
        rec_next       = rec_reg;
        if (accept)
        begin
            crc_next            = in_beat.last_byte ? CRC_INIT : crc_fold_val;
            inside_next         = !in_beat.last_byte;
            rec_valid_next      = 1'b1;
            rec_next.data_byte  = in_beat.data_byte;
            rec_next.last_byte  = in_beat.last_byte;
            rec_next.open_frame = !inside_reg;
            rec_next.fcs        = ~crc_fold_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            inside_reg    <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            inside_reg    <= inside_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

// ----- hw/rtl/frm_emit.sv -----
// Beat sequencer and output register of the frame FCS appender, plus the flag register.
// Depends on frm_pkg; takes the item record from frm_front.
module frm_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               rec_valid,
    input  frm_pkg::frm_rec_t  rec,
    output logic               release_rec,
    output logic               out_valid,
    input  logic               out_stall,
    output frm_pkg::out_beat_t out_beat
);
    import frm_pkg::*;

    logic [7:0] flag_reg;
    logic [7:0] flag_next;
    step_t      step_reg;
    step_t      step_next;
    step_t      cur_step;
    logic       out_load;
    logic       advance;
    logic       final_beat;
    out_beat_t  beat;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_beat_t  out_beat_reg;
    out_beat_t  out_beat_next;

    assign flag_next = cfg_we ? cfg_wdata : flag_reg;

    // A record that continues a frame skips the opening flag.
    always_comb
    begin
        cur_step = step_reg;
        if (step_reg == STEP_OPEN && !rec.open_frame)
            cur_step = STEP_BODY;
    end

    always_comb
    begin
        beat = '{out_byte: rec.data_byte, byte_kind: KIND_BODY, run_last: 1'b0};
        case (cur_step)
            STEP_OPEN:   beat = '{out_byte: flag_reg, byte_kind: KIND_FLAG, run_last: 1'b0};
            STEP_BODY:   beat = '{out_byte: rec.data_byte, byte_kind: KIND_BODY, run_last: 1'b0};
            STEP_FCS_LO: beat = '{out_byte: rec.fcs[7:0], byte_kind: KIND_FCS, run_last: 1'b0};
            STEP_FCS_HI: beat = '{out_byte: rec.fcs[15:8], byte_kind: KIND_FCS, run_last: 1'b0};
            STEP_CLOSE:  beat = '{out_byte: flag_reg, byte_kind: KIND_FLAG, run_last: 1'b0};
            default:     beat = '{out_byte: rec.data_byte, byte_kind: KIND_BODY, run_last: 1'b0};
        endcase
        final_beat    = rec.last_byte ? (cur_step == STEP_CLOSE) : (cur_step == STEP_BODY);
        beat.run_last = final_beat;
    end

    assign out_load    = !out_valid_reg || !out_stall;
    assign advance     = out_load && rec_valid;
    assign release_rec = advance && final_beat;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (out_load)
        begin
            out_valid_next = rec_valid;
            out_beat_next  = beat;
        end
        if (advance)
        begin
            if (final_beat)
                step_next = STEP_OPEN;
            else
                step_next = step_t'(cur_step + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= FLAG_INIT;
            step_reg      <= STEP_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flag_reg      <= flag_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Check bytes and the closing flag belong only to a record that ends its frame.
    a_tail_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (cur_step == STEP_FCS_LO || cur_step == STEP_FCS_HI
                      || cur_step == STEP_CLOSE) |-> rec.last_byte)
        else $error("frame tail step on a record that is not the last byte");

    // A check byte is never the final beat of its record, so another beat follows at once.
    a_fcs_followed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_beat.byte_kind == KIND_FCS |=> out_valid)
        else $error("check byte sent without a following beat");

    // The sequencer returns to its start position whenever a record retires.
    a_step_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        release_rec |=> step_reg == STEP_OPEN)
        else $error("sequencer did not rewind after the last beat of a record");

    // Without a record the sequencer stays at its start position.
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !rec_valid |-> step_reg == STEP_OPEN)
        else $error("sequencer advanced without a record");

endmodule

// ----- hw/rtl/frame_fcs_appender_top.sv -----
// Top level of the frame FCS appender: ties the input stage to the beat sequencer.
// Depends on frm_pkg, frm_front and frm_emit.
//
// Each accepted body byte produces one to five output beats, one per clock while out_stall
// is low: the opening flag when it starts a frame, the byte itself, and after the byte marked
// last the inverted CRC-16 (poly 0x1021, init 0xFFFF) low byte, high byte and the closing flag.
// An input beat therefore occupies the block until the output register has taken the final
// output beat it causes: one beat for a byte in the middle of a frame, two for the opening
// byte, four for the last byte and five for a one-byte frame. The next input beat is taken in
// the same cycle as the final output beat of the current one. The first output beat of an
// input beat passes through the record register and then the output register.
// The flag register resets to 0x7E and should be written only while the block is idle.
module frame_fcs_appender_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  frm_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_stall,
    output frm_pkg::out_beat_t out_beat
);
    import frm_pkg::*;

    logic     rec_valid;
    frm_rec_t rec;
    logic     release_rec;

    frm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_beat     (in_beat),
        .release_rec (release_rec),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    frm_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .rec_valid   (rec_valid),
        .rec         (rec),
        .release_rec (release_rec),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_beat    (out_beat)
    );

endmodule
